>>> design/hrbp_pkg.sv
`timescale 1ns / 1ps

package hrbp_pkg;

    localparam int LENGTH_BITS_DEF  = 24;
    localparam int VERSION_BITS_DEF = 16;
    localparam int CFG_BITS         = 24;

    localparam logic [CFG_BITS-1:0] MAX_BODY_RESET = 24'd1048576;

    typedef enum logic [4:0] {
        PS_METHOD_START = 5'd0,
        PS_METHOD       = 5'd1,
        PS_URI          = 5'd2,
        PS_VH           = 5'd3,
        PS_VT1          = 5'd4,
        PS_VT2          = 5'd5,
        PS_VP           = 5'd6,
        PS_VSLASH       = 5'd7,
        PS_MAJ_START    = 5'd8,
        PS_MAJ          = 5'd9,
        PS_MIN_START    = 5'd10,
        PS_MIN          = 5'd11,
        PS_NL1          = 5'd12,
        PS_LINE_START   = 5'd13,
        PS_LWS          = 5'd14,
        PS_NAME         = 5'd15,
        PS_SPACE        = 5'd16,
        PS_VALUE        = 5'd17,
        PS_NL2          = 5'd18,
        PS_NL3          = 5'd19,
        PS_BODY         = 5'd20,
        PS_DONE         = 5'd21
    } t_parse_state;

    localparam logic [1:0] STAT_PENDING = 2'd0;
    localparam logic [1:0] STAT_GOOD    = 2'd1;
    localparam logic [1:0] STAT_BAD     = 2'd2;

    localparam logic [2:0] CLS_DELIM  = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI    = 3'd2;
    localparam logic [2:0] CLS_HNAME  = 3'd3;
    localparam logic [2:0] CLS_HVALUE = 3'd4;
    localparam logic [2:0] CLS_BODY   = 3'd5;

    localparam logic [2:0] FD_NONE     = 3'd0;
    localparam logic [2:0] FD_METHOD   = 3'd1;
    localparam logic [2:0] FD_URI      = 3'd2;
    localparam logic [2:0] FD_MAJOR    = 3'd3;
    localparam logic [2:0] FD_MINOR    = 3'd4;
    localparam logic [2:0] FD_HEADER   = 3'd5;
    localparam logic [2:0] FD_HDRS_END = 3'd6;
    localparam logic [2:0] FD_BODY     = 3'd7;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CTL_MAX = 8'h1f;

    localparam logic [3:0] NAME_LEN = 4'd14;
    localparam logic [3:0] NO_MATCH = 4'd15;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CH_CTL_MAX) || (b == CH_DEL);
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic separator_byte(input logic [7:0] b);
        logic r;
        case (b)
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
            8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: begin
                r = 1'b1;
            end
            default: begin
                r = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !separator_byte(b);
    endfunction

    // lower-case "content-length"
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6e;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2d;
            4'd8:    c = 8'h6c;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6e;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] match_step(input logic [3:0] pos, input logic [7:0] b);
        logic [7:0] lc;
        lc = ((b >= 8'h41) && (b <= 8'h5a)) ? (b + 8'd32) : b;
        return ((pos < NAME_LEN) && (lc == name_char(pos))) ? (pos + 4'd1) : NO_MATCH;
    endfunction

endpackage

>>> design/http_request_byte_parser_core.sv
// HTTP/1.x request parser, one byte per transaction. Each accepted byte yields exactly one
// result carrying the echoed byte, a status (pending, good, bad), the field class of the
// byte and a field-complete mark, plus the finished version number or the decoded
// Content-Length where those complete. Throughput is one byte per clock while the output
// is not stalled: the byte lands in an input register, one pass of parse logic against
// the state registers produces the result, and that result sits in an output register;
// a stalled output only blocks input once both registers are full. A bad byte leaves
// the parse state untouched; after a good request every byte is pending until a byte
// with restart set. max_body_length may be written at any time the parser is idle; the
// configuration port is always ready. No startup clearing is needed.
`timescale 1ns / 1ps

module http_request_byte_parser_core #(
    parameter int LENGTH_BITS  = hrbp_pkg::LENGTH_BITS_DEF,
    parameter int VERSION_BITS = hrbp_pkg::VERSION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_byte_in,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [7:0]                      o_byte_out,
    output logic [2:0]                      o_byte_class,
    output logic [2:0]                      o_field_done,
    output logic [VERSION_BITS-1:0]         o_version_value,
    output logic [LENGTH_BITS-1:0]          o_body_length,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hrbp_pkg::CFG_BITS-1:0]   i_cfg_data
);

    localparam int CMP_BITS = (LENGTH_BITS > hrbp_pkg::CFG_BITS) ? LENGTH_BITS
                                                                 : hrbp_pkg::CFG_BITS;

    function automatic logic [VERSION_BITS-1:0] ver_acc(input logic [VERSION_BITS-1:0] acc,
                                                         input logic [3:0] d);
        logic [VERSION_BITS+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VERSION_BITS{1'b0}}, d};
        return (v[VERSION_BITS+3:VERSION_BITS] != 4'd0) ? '1 : v[VERSION_BITS-1:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_acc(input logic [LENGTH_BITS-1:0] acc,
                                                        input logic [3:0] d);
        logic [LENGTH_BITS+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{LENGTH_BITS{1'b0}}, d};
        return (v[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1 : v[LENGTH_BITS-1:0];
    endfunction

    logic [hrbp_pkg::CFG_BITS-1:0] r_max_len;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_restart;

    hrbp_pkg::t_parse_state r_state, n_state;
    logic [VERSION_BITS-1:0] r_ver_acc, n_ver_acc;
    logic                    r_hdr_seen, n_hdr_seen;
    logic [LENGTH_BITS-1:0]  r_len, n_len;
    logic [LENGTH_BITS-1:0]  r_body_cnt, n_body_cnt;
    logic [3:0]              r_match_pos, n_match_pos;
    logic                    r_is_len_hdr, n_is_len_hdr;

    logic                    r_out_valid;
    logic [1:0]              r_status, n_status;
    logic [7:0]              r_byte_out;
    logic [2:0]              r_class, n_class;
    logic [2:0]              r_fd, n_fd;
    logic [VERSION_BITS-1:0] r_ver_out, n_ver_out;
    logic [LENGTH_BITS-1:0]  r_blen_out, n_blen_out;

    logic                    adv;
    logic                    step;
    logic [7:0]              b;
    logic [3:0]              dig;
    logic [LENGTH_BITS-1:0]  body_inc;
    logic                    too_long;

    assign adv         = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && adv;
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    assign b        = r_in_byte;
    assign dig      = 4'(r_in_byte - hrbp_pkg::CH_ZERO);
    assign body_inc = r_body_cnt + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign too_long = CMP_BITS'(r_len) >= CMP_BITS'(r_max_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= hrbp_pkg::MAX_BODY_RESET;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte    <= i_byte_in;
            r_in_restart <= i_restart;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ver_acc    = r_ver_acc;
        n_hdr_seen   = r_hdr_seen;
        n_len        = r_len;
        n_body_cnt   = r_body_cnt;
        n_match_pos  = r_match_pos;
        n_is_len_hdr = r_is_len_hdr;
        n_status     = hrbp_pkg::STAT_PENDING;
        n_class      = hrbp_pkg::CLS_DELIM;
        n_fd         = hrbp_pkg::FD_NONE;
        n_ver_out    = '0;
        n_blen_out   = '0;

        if (r_in_restart) begin
            n_state      = hrbp_pkg::PS_METHOD_START;
            n_ver_acc    = '0;
            n_hdr_seen   = 1'b0;
            n_len        = '0;
            n_body_cnt   = '0;
            n_match_pos  = 4'd0;
            n_is_len_hdr = 1'b0;
        end else begin
            case (r_state)
                hrbp_pkg::PS_METHOD_START: begin
                    if (hrbp_pkg::is_token(b)) begin
                        n_state = hrbp_pkg::PS_METHOD;
                        n_class = hrbp_pkg::CLS_METHOD;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_METHOD: begin
                    if (b == hrbp_pkg::CH_SPACE) begin
                        n_state = hrbp_pkg::PS_URI;
                        n_fd    = hrbp_pkg::FD_METHOD;
                    end else if (hrbp_pkg::is_token(b)) begin
                        n_class = hrbp_pkg::CLS_METHOD;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_URI: begin
                    if (b == hrbp_pkg::CH_SPACE) begin
                        n_state = hrbp_pkg::PS_VH;
                        n_fd    = hrbp_pkg::FD_URI;
                    end else if (hrbp_pkg::is_ctl(b)) begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end else begin
                        n_class = hrbp_pkg::CLS_URI;
                    end
                end
                hrbp_pkg::PS_VH: begin
                    if (b == hrbp_pkg::CH_H) n_state = hrbp_pkg::PS_VT1;
                    else n_status = hrbp_pkg::STAT_BAD;
                end
                hrbp_pkg::PS_VT1: begin
                    if (b == hrbp_pkg::CH_T) n_state = hrbp_pkg::PS_VT2;
                    else n_status = hrbp_pkg::STAT_BAD;
                end
                hrbp_pkg::PS_VT2: begin
                    if (b == hrbp_pkg::CH_T) n_state = hrbp_pkg::PS_VP;
                    else n_status = hrbp_pkg::STAT_BAD;
                end
                hrbp_pkg::PS_VP: begin
                    if (b == hrbp_pkg::CH_P) n_state = hrbp_pkg::PS_VSLASH;
                    else n_status = hrbp_pkg::STAT_BAD;
                end
                hrbp_pkg::PS_VSLASH: begin
                    if (b == hrbp_pkg::CH_SLASH) begin
                        n_ver_acc = '0;
                        n_state   = hrbp_pkg::PS_MAJ_START;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_MAJ_START, hrbp_pkg::PS_MIN_START: begin
                    if (hrbp_pkg::digit_byte(b)) begin
                        n_ver_acc = ver_acc(r_ver_acc, dig);
                        n_state   = (r_state == hrbp_pkg::PS_MAJ_START) ? hrbp_pkg::PS_MAJ
                                                                        : hrbp_pkg::PS_MIN;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_MAJ, hrbp_pkg::PS_MIN: begin
                    if (hrbp_pkg::digit_byte(b)) begin
                        n_ver_acc = ver_acc(r_ver_acc, dig);
                    end else if (r_state == hrbp_pkg::PS_MAJ && b == hrbp_pkg::CH_DOT) begin
                        n_fd      = hrbp_pkg::FD_MAJOR;
                        n_ver_out = r_ver_acc;
                        n_ver_acc = '0;
                        n_state   = hrbp_pkg::PS_MIN_START;
                    end else if (r_state == hrbp_pkg::PS_MIN && b == hrbp_pkg::CH_CR) begin
                        n_fd      = hrbp_pkg::FD_MINOR;
                        n_ver_out = r_ver_acc;
                        n_ver_acc = '0;
                        n_state   = hrbp_pkg::PS_NL1;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_NL1, hrbp_pkg::PS_NL2: begin
                    if (b == hrbp_pkg::CH_LF) n_state = hrbp_pkg::PS_LINE_START;
                    else n_status = hrbp_pkg::STAT_BAD;
                end
                hrbp_pkg::PS_LINE_START: begin
                    if (b == hrbp_pkg::CH_CR) begin
                        n_state = hrbp_pkg::PS_NL3;
                    end else if (r_hdr_seen &&
                                 (b == hrbp_pkg::CH_SPACE || b == hrbp_pkg::CH_TAB)) begin
                        n_state = hrbp_pkg::PS_LWS;
                    end else if (hrbp_pkg::is_token(b)) begin
                        n_match_pos = hrbp_pkg::match_step(4'd0, b);
                        n_state     = hrbp_pkg::PS_NAME;
                        n_class     = hrbp_pkg::CLS_HNAME;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_LWS: begin
                    if (b == hrbp_pkg::CH_CR) begin
                        n_state = hrbp_pkg::PS_NL2;
                    end else if (b == hrbp_pkg::CH_SPACE || b == hrbp_pkg::CH_TAB) begin
                        n_state = r_state;
                    end else if (hrbp_pkg::is_ctl(b)) begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end else begin
                        n_state = hrbp_pkg::PS_VALUE;
                        n_class = hrbp_pkg::CLS_HVALUE;
                        if (r_is_len_hdr && hrbp_pkg::digit_byte(b)) n_len = len_acc(r_len, dig);
                    end
                end
                hrbp_pkg::PS_NAME: begin
                    if (b == hrbp_pkg::CH_COLON) begin
                        n_is_len_hdr = (r_match_pos == hrbp_pkg::NAME_LEN);
                        if (r_match_pos == hrbp_pkg::NAME_LEN) n_len = '0;
                        n_state = hrbp_pkg::PS_SPACE;
                    end else if (hrbp_pkg::is_token(b)) begin
                        n_match_pos = hrbp_pkg::match_step(r_match_pos, b);
                        n_class     = hrbp_pkg::CLS_HNAME;
                    end else begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end
                end
                hrbp_pkg::PS_SPACE: begin
                    if (b == hrbp_pkg::CH_SPACE) n_state = hrbp_pkg::PS_VALUE;
                    else n_status = hrbp_pkg::STAT_BAD;
                end
                hrbp_pkg::PS_VALUE: begin
                    if (b == hrbp_pkg::CH_CR) begin
                        n_fd       = hrbp_pkg::FD_HEADER;
                        n_hdr_seen = 1'b1;
                        n_state    = hrbp_pkg::PS_NL2;
                    end else if (hrbp_pkg::is_ctl(b)) begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end else begin
                        n_class = hrbp_pkg::CLS_HVALUE;
                        if (r_is_len_hdr && hrbp_pkg::digit_byte(b)) n_len = len_acc(r_len, dig);
                    end
                end
                hrbp_pkg::PS_NL3: begin
                    if (b != hrbp_pkg::CH_LF || too_long) begin
                        n_status = hrbp_pkg::STAT_BAD;
                    end else begin
                        n_fd       = hrbp_pkg::FD_HDRS_END;
                        n_blen_out = r_len;
                        n_body_cnt = '0;
                        if (r_len == '0) begin
                            n_status = hrbp_pkg::STAT_GOOD;
                            n_state  = hrbp_pkg::PS_DONE;
                        end else begin
                            n_state = hrbp_pkg::PS_BODY;
                        end
                    end
                end
                hrbp_pkg::PS_BODY: begin
                    n_class    = hrbp_pkg::CLS_BODY;
                    n_body_cnt = body_inc;
                    if (body_inc == r_len) begin
                        n_status = hrbp_pkg::STAT_GOOD;
                        n_fd     = hrbp_pkg::FD_BODY;
                        n_state  = hrbp_pkg::PS_DONE;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hrbp_pkg::PS_METHOD_START;
            r_ver_acc    <= '0;
            r_hdr_seen   <= 1'b0;
            r_len        <= '0;
            r_body_cnt   <= '0;
            r_match_pos  <= 4'd0;
            r_is_len_hdr <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_state      <= n_state;
                r_ver_acc    <= n_ver_acc;
                r_hdr_seen   <= n_hdr_seen;
                r_len        <= n_len;
                r_body_cnt   <= n_body_cnt;
                r_match_pos  <= n_match_pos;
                r_is_len_hdr <= n_is_len_hdr;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status   <= n_status;
            r_byte_out <= r_in_byte;
            r_class    <= n_class;
            r_fd       <= n_fd;
            r_ver_out  <= n_ver_out;
            r_blen_out <= n_blen_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_byte_out      = r_byte_out;
    assign o_byte_class    = r_class;
    assign o_field_done    = r_fd;
    assign o_version_value = r_ver_out;
    assign o_body_length   = r_blen_out;

endmodule

>>> design/hrbp_checker.sv
`timescale 1ns / 1ps

module hrbp_checker #(
    parameter int LENGTH_BITS  = hrbp_pkg::LENGTH_BITS_DEF,
    parameter int VERSION_BITS = hrbp_pkg::VERSION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic [1:0]              o_status,
    input  logic [7:0]              o_byte_out,
    input  logic [2:0]              o_byte_class,
    input  logic [2:0]              o_field_done,
    input  logic [VERSION_BITS-1:0] o_version_value,
    input  logic [LENGTH_BITS-1:0]  o_body_length
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_byte_out) && $stable(o_field_done) && $stable(o_body_length))
        else $error("result changed while stalled");

    a_version_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_done != hrbp_pkg::FD_MAJOR &&
        o_field_done != hrbp_pkg::FD_MINOR |-> o_version_value == '0)
        else $error("version value outside version completion");

    a_length_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_done != hrbp_pkg::FD_HDRS_END |-> o_body_length == '0)
        else $error("body length outside end of headers");

    a_good_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == hrbp_pkg::STAT_GOOD |->
        o_field_done == hrbp_pkg::FD_HDRS_END || o_field_done == hrbp_pkg::FD_BODY)
        else $error("good status without completion mark");

    a_bad_is_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == hrbp_pkg::STAT_BAD |->
        o_byte_class == hrbp_pkg::CLS_DELIM && o_field_done == hrbp_pkg::FD_NONE)
        else $error("bad byte carries a class or field mark");

endmodule

bind http_request_byte_parser_core hrbp_checker #(
    .LENGTH_BITS  (LENGTH_BITS),
    .VERSION_BITS (VERSION_BITS)
) u_hrbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_byte_out      (o_byte_out),
    .o_byte_class    (o_byte_class),
    .o_field_done    (o_field_done),
    .o_version_value (o_version_value),
    .o_body_length   (o_body_length)
);

>>> tb/http_request_byte_parser_core_test.sv
`timescale 1ns / 1ps

module http_request_byte_parser_core_test;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data;
        logic [2:0]  cls;
        logic [2:0]  done;
        logic [15:0] ver;
        logic [23:0] blen;
    } t_byte_verdict;

    class t_parse_tracker;
        hrbp_pkg::t_parse_state pst;
        logic [15:0]   ver_acc;
        logic          hdr_seen;
        logic [23:0]   len_val;
        logic [23:0]   body_cnt;
        logic [3:0]    name_pos;
        logic          is_len_hdr;
        logic [23:0]   max_len;
        string         length_name = "content-length";
        t_byte_verdict pending_verdicts[$];
        int            mismatches;

        function new();
            clear_parse();
            max_len = hrbp_pkg::MAX_BODY_RESET;
            mismatches = 0;
        endfunction

        function void clear_parse();
            pst = hrbp_pkg::PS_METHOD_START;
            ver_acc = '0;
            hdr_seen = 1'b0;
            len_val = '0;
            body_cnt = '0;
            name_pos = '0;
            is_len_hdr = 1'b0;
        endfunction

        function bit ctl_char(logic [7:0] b);
            return b <= hrbp_pkg::CH_CTL_MAX || b == hrbp_pkg::CH_DEL;
        endfunction

        function bit digit_char(logic [7:0] b);
            return b >= hrbp_pkg::CH_ZERO && b <= hrbp_pkg::CH_NINE;
        endfunction

        function bit blank_char(logic [7:0] b);
            return b == hrbp_pkg::CH_SPACE || b == hrbp_pkg::CH_TAB;
        endfunction

        function bit separator_char(logic [7:0] b);
            case (b)
                "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
                "/", "[", "]", "?", "=", "{", "}", hrbp_pkg::CH_SPACE,
                hrbp_pkg::CH_TAB: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit token_char(logic [7:0] b);
            return !b[7] && !ctl_char(b) && !separator_char(b);
        endfunction

        function logic [31:0] dec_step(logic [31:0] acc, logic [7:0] b, logic [31:0] lim);
            logic [31:0] v;
            v = acc * 10 + (b - hrbp_pkg::CH_ZERO);
            return (v > lim) ? lim : v;
        endfunction

        function void match_letter(logic [7:0] b);
            logic [7:0] lc;
            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            if (name_pos < hrbp_pkg::NAME_LEN && lc == length_name[name_pos])
                name_pos = name_pos + 4'd1;
            else
                name_pos = hrbp_pkg::NO_MATCH;
        endfunction

        function void value_char(logic [7:0] b);
            if (is_len_hdr && digit_char(b))
                len_val = 24'(dec_step({8'd0, len_val}, b, 32'hFF_FFFF));
        endfunction

        function void accept_byte(logic [7:0] b, logic rs);
            t_byte_verdict v;
            v = '{status: hrbp_pkg::STAT_PENDING, data: b, cls: hrbp_pkg::CLS_DELIM,
                  done: hrbp_pkg::FD_NONE, ver: '0, blen: '0};
            if (rs) begin
                clear_parse();
            end else begin
                case (pst)
                    hrbp_pkg::PS_METHOD_START: begin
                        if (token_char(b)) begin
                            pst = hrbp_pkg::PS_METHOD;
                            v.cls = hrbp_pkg::CLS_METHOD;
                        end else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_METHOD: begin
                        if (b == hrbp_pkg::CH_SPACE) begin
                            pst = hrbp_pkg::PS_URI;
                            v.done = hrbp_pkg::FD_METHOD;
                        end else if (token_char(b)) v.cls = hrbp_pkg::CLS_METHOD;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_URI: begin
                        if (b == hrbp_pkg::CH_SPACE) begin
                            pst = hrbp_pkg::PS_VH;
                            v.done = hrbp_pkg::FD_URI;
                        end else if (ctl_char(b)) v.status = hrbp_pkg::STAT_BAD;
                        else v.cls = hrbp_pkg::CLS_URI;
                    end
                    hrbp_pkg::PS_VH: begin
                        if (b == hrbp_pkg::CH_H) pst = hrbp_pkg::PS_VT1;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_VT1: begin
                        if (b == hrbp_pkg::CH_T) pst = hrbp_pkg::PS_VT2;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_VT2: begin
                        if (b == hrbp_pkg::CH_T) pst = hrbp_pkg::PS_VP;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_VP: begin
                        if (b == hrbp_pkg::CH_P) pst = hrbp_pkg::PS_VSLASH;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_VSLASH: begin
                        if (b == hrbp_pkg::CH_SLASH) begin
                            ver_acc = '0;
                            pst = hrbp_pkg::PS_MAJ_START;
                        end else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_MAJ_START, hrbp_pkg::PS_MIN_START: begin
                        if (digit_char(b)) begin
                            ver_acc = 16'(dec_step({16'd0, ver_acc}, b, 32'hFFFF));
                            pst = (pst == hrbp_pkg::PS_MAJ_START) ? hrbp_pkg::PS_MAJ
                                                                  : hrbp_pkg::PS_MIN;
                        end else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_MAJ, hrbp_pkg::PS_MIN: begin
                        if (digit_char(b)) begin
                            ver_acc = 16'(dec_step({16'd0, ver_acc}, b, 32'hFFFF));
                        end else if (pst == hrbp_pkg::PS_MAJ && b == hrbp_pkg::CH_DOT) begin
                            v.done = hrbp_pkg::FD_MAJOR;
                            v.ver = ver_acc;
                            ver_acc = '0;
                            pst = hrbp_pkg::PS_MIN_START;
                        end else if (pst == hrbp_pkg::PS_MIN && b == hrbp_pkg::CH_CR) begin
                            v.done = hrbp_pkg::FD_MINOR;
                            v.ver = ver_acc;
                            ver_acc = '0;
                            pst = hrbp_pkg::PS_NL1;
                        end else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_NL1, hrbp_pkg::PS_NL2: begin
                        if (b == hrbp_pkg::CH_LF) pst = hrbp_pkg::PS_LINE_START;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_LINE_START: begin
                        if (b == hrbp_pkg::CH_CR) pst = hrbp_pkg::PS_NL3;
                        else if (hdr_seen && blank_char(b)) pst = hrbp_pkg::PS_LWS;
                        else if (token_char(b)) begin
                            name_pos = '0;
                            match_letter(b);
                            pst = hrbp_pkg::PS_NAME;
                            v.cls = hrbp_pkg::CLS_HNAME;
                        end else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_LWS: begin
                        if (b == hrbp_pkg::CH_CR) pst = hrbp_pkg::PS_NL2;
                        else if (blank_char(b)) begin
                        end else if (ctl_char(b)) v.status = hrbp_pkg::STAT_BAD;
                        else begin
                            pst = hrbp_pkg::PS_VALUE;
                            v.cls = hrbp_pkg::CLS_HVALUE;
                            value_char(b);
                        end
                    end
                    hrbp_pkg::PS_NAME: begin
                        if (b == hrbp_pkg::CH_COLON) begin
                            is_len_hdr = (name_pos == hrbp_pkg::NAME_LEN);
                            if (is_len_hdr) len_val = '0;
                            pst = hrbp_pkg::PS_SPACE;
                        end else if (token_char(b)) begin
                            match_letter(b);
                            v.cls = hrbp_pkg::CLS_HNAME;
                        end else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_SPACE: begin
                        if (b == hrbp_pkg::CH_SPACE) pst = hrbp_pkg::PS_VALUE;
                        else v.status = hrbp_pkg::STAT_BAD;
                    end
                    hrbp_pkg::PS_VALUE: begin
                        if (b == hrbp_pkg::CH_CR) begin
                            v.done = hrbp_pkg::FD_HEADER;
                            hdr_seen = 1'b1;
                            pst = hrbp_pkg::PS_NL2;
                        end else if (ctl_char(b)) v.status = hrbp_pkg::STAT_BAD;
                        else begin
                            v.cls = hrbp_pkg::CLS_HVALUE;
                            value_char(b);
                        end
                    end
                    hrbp_pkg::PS_NL3: begin
                        if (b != hrbp_pkg::CH_LF || len_val >= max_len) begin
                            v.status = hrbp_pkg::STAT_BAD;
                        end else begin
                            v.done = hrbp_pkg::FD_HDRS_END;
                            v.blen = len_val;
                            body_cnt = '0;
                            if (len_val == 0) begin
                                v.status = hrbp_pkg::STAT_GOOD;
                                pst = hrbp_pkg::PS_DONE;
                            end else pst = hrbp_pkg::PS_BODY;
                        end
                    end
                    hrbp_pkg::PS_BODY: begin
                        v.cls = hrbp_pkg::CLS_BODY;
                        body_cnt = body_cnt + 24'd1;
                        if (body_cnt == len_val) begin
                            v.status = hrbp_pkg::STAT_GOOD;
                            v.done = hrbp_pkg::FD_BODY;
                            pst = hrbp_pkg::PS_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        task report(string msg);
            if (mismatches < 40) $display("MISMATCH %s", msg);
            mismatches++;
        endtask

        task check_verdict(t_byte_verdict got);
            t_byte_verdict want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result for byte %02h with nothing outstanding", got.data));
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.status !== want.status)
                report($sformatf("byte %02h status %0d, want %0d", want.data, got.status,
                                 want.status));
            if (got.data !== want.data)
                report($sformatf("byte_out %02h, want %02h", got.data, want.data));
            if (got.cls !== want.cls)
                report($sformatf("byte %02h class %0d, want %0d", want.data, got.cls, want.cls));
            if (got.done !== want.done)
                report($sformatf("byte %02h field_done %0d, want %0d", want.data, got.done,
                                 want.done));
            if (got.ver !== want.ver)
                report($sformatf("byte %02h version %0d, want %0d", want.data, got.ver,
                                 want.ver));
            if (got.blen !== want.blen)
                report($sformatf("byte %02h body_length %0d, want %0d", want.data, got.blen,
                                 want.blen));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_restart;
    logic        out_ready = 1'b0;
    logic        cfg_valid;
    logic [23:0] cfg_data;

    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status_o;
    logic [7:0]  byte_o;
    logic [2:0]  class_o;
    logic [2:0]  done_o;
    logic [15:0] version_o;
    logic [23:0] length_o;
    logic        cfg_ready;

    t_parse_tracker tracker;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             bytes_sent;

    http_request_byte_parser_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_byte_in       (in_byte),
        .i_restart       (in_restart),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status_o),
        .o_byte_out      (byte_o),
        .o_byte_class    (class_o),
        .o_field_done    (done_o),
        .o_version_value (version_o),
        .o_body_length   (length_o),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        t_byte_verdict got;
        if (rst_n && out_valid && out_ready) begin
            got = '{status: status_o, data: byte_o, cls: class_o, done: done_o,
                    ver: version_o, blen: length_o};
            tracker.check_verdict(got);
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_restart <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.accept_byte(b, rs);
        if (!rs) bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [23:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.max_len = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        int i;
        for (i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    endfunction

    function automatic void end_line(ref logic [7:0] q[$]);
        q.insert(q.size(), hrbp_pkg::CH_CR);
        q.insert(q.size(), hrbp_pkg::CH_LF);
    endfunction

    function automatic string version_text();
        case ($urandom_range(9))
            0: return "0";
            1: return "2";
            2: return "10";
            3: return "99999";
            4: return "007";
            5: return "65535";
            6: return "65536";
            default: return "1";
        endcase
    endfunction

    function automatic string length_text();
        int unsigned top;
        int unsigned v;
        string s;
        if (tracker.max_len != 0 && $urandom_range(3) != 0) begin
            top = tracker.max_len - 1;
            if (top > 24) top = 24;
            v = $urandom_range(top, 0);
        end else if ($urandom_range(1)) begin
            v = $urandom_range(24'hFF_FFFF, tracker.max_len);
        end else begin
            return "99999999999";
        end
        s = $sformatf("%0d", v);
        if ($urandom_range(4) == 0) s = {"00", s};
        if ($urandom_range(5) == 0) s = {s.substr(0, 0), "x ", s.substr(1, s.len() - 1)};
        return s;
    endfunction

    task automatic send_request();
        logic [7:0]  req[$];
        string       txt;
        logic [7:0]  c;
        int unsigned n;
        int unsigned cut;
        int          i;
        send_item(8'($urandom_range(255)), 1'b1);
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(12, 3);
            repeat (n) send_item(8'($urandom_range(255)), ($urandom_range(19) == 0));
            return;
        end
        case ($urandom_range(5))
            0: push_text(req, "GET");
            1: push_text(req, "POST");
            2: push_text(req, "PUT");
            3: push_text(req, "M-SEARCH");
            4: push_text(req, "options");
            default: begin
                n = $urandom_range(6, 1);
                while (n > 0) begin
                    c = 8'($urandom_range(126, 33));
                    if (tracker.token_char(c)) begin
                        req.insert(req.size(), c);
                        n--;
                    end
                end
            end
        endcase
        req.insert(req.size(), hrbp_pkg::CH_SPACE);
        req.insert(req.size(), hrbp_pkg::CH_SLASH);
        n = $urandom_range(8);
        repeat (n) begin
            c = 8'($urandom_range(255, 33));
            req.insert(req.size(), (c == hrbp_pkg::CH_DEL) ? "~" : c);
        end
        push_text(req, " HTTP/");
        push_text(req, version_text());
        req.insert(req.size(), hrbp_pkg::CH_DOT);
        push_text(req, version_text());
        end_line(req);
        n = $urandom_range(4);
        repeat (n) begin
            case ($urandom_range(3))
                0: begin
                    txt = "content-length";
                    for (i = 0; i < txt.len(); i++) begin
                        c = txt[i];
                        if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
                        req.insert(req.size(), c);
                    end
                    push_text(req, ": ");
                    push_text(req, length_text());
                end
                1: push_text(req, "Host: h1.local");
                2: begin
                    case ($urandom_range(3))
                        0: push_text(req, "Content-Lengt: 7");
                        1: push_text(req, "Content-Lengthy: 7");
                        2: push_text(req, "content_length: 7");
                        default: push_text(req, "XContent-Length: 7");
                    endcase
                end
                default: begin
                    cut = $urandom_range(6, 1);
                    while (cut > 0) begin
                        c = 8'($urandom_range(126, 33));
                        if (tracker.token_char(c)) begin
                            req.insert(req.size(), c);
                            cut--;
                        end
                    end
                    push_text(req, ": ");
                    cut = $urandom_range(8);
                    repeat (cut) begin
                        c = 8'($urandom_range(255, 32));
                        req.insert(req.size(), (c == hrbp_pkg::CH_DEL) ? "~" : c);
                    end
                end
            endcase
            end_line(req);
            if ($urandom_range(6) == 0) begin
                req.insert(req.size(),
                           $urandom_range(1) ? hrbp_pkg::CH_SPACE : hrbp_pkg::CH_TAB);
                push_text(req, $sformatf("%0d", $urandom_range(9)));
                end_line(req);
            end
        end
        end_line(req);
        cut = ($urandom_range(9) == 0) ? $urandom_range(req.size() - 1) : req.size();
        for (i = 0; i < cut; i++) begin
            if ($urandom_range(32) == 0)
                send_item(8'($urandom_range(255)), ($urandom_range(39) == 0));
            send_item(req[i], 1'b0);
        end
        if (tracker.pst == hrbp_pkg::PS_BODY) begin
            n = 32'(tracker.len_val - tracker.body_cnt);
            if (n > 80) n = 80;
            repeat (n) send_item(8'($urandom_range(255)), 1'b0);
        end
        n = $urandom_range(2);
        repeat (n) send_item(8'($urandom_range(255)), 1'b0);
    endtask

    initial begin
        #20_000_000;
        $display("http_request_byte_parser_core regression: fail");
        $finish;
    end

    initial begin
        logic [7:0]  basic[$];
        logic [23:0] limits[5];
        int          seg;
        int          start;
        int          i;
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        in_restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        limits = '{hrbp_pkg::MAX_BODY_RESET, 24'hFF_FFFF, 24'd30, 24'd0, 24'd1};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // bad first bytes, a minimal good request, then a byte in the done state
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        push_text(basic, "GET / HTTP/1.1");
        end_line(basic);
        end_line(basic);
        for (i = 0; i < basic.size(); i++) send_item(basic[i], 1'b0);
        send_item("x", 1'b0);

        for (seg = 0; seg < 5; seg++) begin
            if (seg > 0) write_max_length(limits[seg]);
            send_idle_pct = (seg % 4 == 1) ? 78 : (seg % 4 == 3) ? 18 : 0;
            recv_stall_pct = (seg % 4 == 2) ? 78 : (seg % 4 == 3) ? 18 : 0;
            start = bytes_sent;
            while (bytes_sent - start < 80) send_request();
            drain();
        end
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("http_request_byte_parser_core regression: pass");
        else
            $display("http_request_byte_parser_core regression: fail");
        $finish;
    end

endmodule
